// File: rtl/see_pkg.sv
package see_pkg;

  localparam int DATA_W          = 32;
  localparam int CMD_W           = 2;
  localparam int OPC_W           = 2;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 128;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_APPLY  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_WAIT,
    S_POP,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_RUN,
    ALU_FIN
  } alu_state_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// File: rtl/see_if.sv
interface see_in_if import see_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] operand_value;
  logic [OPC_W-1:0]         operator_code;

  modport source (output valid, output command, output operand_value,
                  output operator_code, input ready);
  modport sink   (input valid, input command, input operand_value,
                  input operator_code, output ready);
endinterface

interface see_out_if import see_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// File: rtl/see_ram.sv
module see_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/see_alu.sv
module see_alu import see_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int CNT_W = $clog2(DATA_W);

  alu_state_t        state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] d_r, d_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [DATA_W:0]   opa, opb;
  logic              cin;
  logic [DATA_W+1:0] sum;
  logic              ge;
  logic [DATA_W-1:0] mag_a, mag_b;

  // shared adder: add, subtract, multiply step, divide step
  always_comb begin
    case (op_r)
      OP_ADD: begin
        opa = {1'b0, acc_r};
        opb = {1'b0, d_r};
        cin = 1'b0;
      end
      OP_SUB: begin
        opa = {1'b0, acc_r};
        opb = ~{1'b0, d_r};
        cin = 1'b1;
      end
      OP_MUL: begin
        opa = {1'b0, acc_r[DATA_W-2:0], 1'b0};
        opb = {1'b0, (q_r[DATA_W-1] ? d_r : '0)};
        cin = 1'b0;
      end
      default: begin
        opa = {acc_r, q_r[DATA_W-1]};
        opb = ~{1'b0, d_r};
        cin = 1'b1;
      end
    endcase
    sum = {1'b0, opa} + {1'b0, opb} + {{(DATA_W+1){1'b0}}, cin};
    ge  = sum[DATA_W+1];
  end

  assign mag_a = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
  assign mag_b = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    d_nxt     = d_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ALU_IDLE: begin
        if (req.start) begin
          op_nxt    = req.op;
          neg_nxt   = req.a[DATA_W-1] ^ req.b[DATA_W-1];
          state_nxt = ALU_RUN;
          case (req.op)
            OP_MUL: begin
              acc_nxt = '0;
              q_nxt   = req.b;
              d_nxt   = req.a;
              cnt_nxt = CNT_W'(DATA_W - 1);
            end
            OP_DIV: begin
              acc_nxt = '0;
              q_nxt   = mag_a;
              d_nxt   = mag_b;
              cnt_nxt = CNT_W'(DATA_W - 1);
            end
            default: begin
              acc_nxt = req.a;
              d_nxt   = req.b;
              cnt_nxt = '0;
            end
          endcase
        end
      end
      ALU_RUN: begin
        case (op_r)
          OP_MUL: begin
            acc_nxt = sum[DATA_W-1:0];
            q_nxt   = {q_r[DATA_W-2:0], 1'b0};
          end
          OP_DIV: begin
            acc_nxt = ge ? sum[DATA_W-1:0] : {acc_r[DATA_W-2:0], q_r[DATA_W-1]};
            q_nxt   = {q_r[DATA_W-2:0], ge};
          end
          default: begin
            acc_nxt = sum[DATA_W-1:0];
          end
        endcase
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ALU_FIN;
        end
      end
      ALU_FIN: begin
        state_nxt = ALU_IDLE;
      end
      default: begin
        state_nxt = ALU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ALU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done   = (state_r == ALU_FIN);
  assign rsp.result = (op_r == OP_DIV) ? (neg_r ? (~q_r + 1'b1) : q_r) : acc_r;

endmodule

// File: rtl/stack_expression_evaluator_unit.sv
// channel  dir  payload                                  beat when
// in_ch    in   command, operand_value, operator_code    valid & ready
// out_ch   out  result_value, status                     valid & ready
//
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// Push, unused command, underflow or sticky fault go straight to the hand-off;
// finish first reads the top entry; divide by zero stops after two stack reads.
// Arithmetic runs two stack reads, the shared adder loop (radix-2, 32 steps for
// multiply/divide), the write-back and the result hand-off.
// A full result register holds the sequencer until out_ch takes the beat.
// Reset (rst_n low, synchronous) empties the stack and clears the fault.
module stack_expression_evaluator_unit import see_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  see_in_if.sink      in_ch,
  see_out_if.source   out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  seq_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           sticky_r, sticky_nxt;
  status_t           status_r, status_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_res_r, out_res_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  see_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  see_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sticky_nxt     = sticky_r;
    status_nxt     = status_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_res_nxt    = out_res_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = in_ch.operand_value;
    ram_raddr      = AW'(count_r - CW'(1));
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;
    alu_req.a      = a_r;
    alu_req.b      = ram_rdata;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt    = '0;
          status_nxt = ST_OK;
          op_nxt     = op_t'(in_ch.operator_code);
          state_nxt  = S_DONE;
          if (sticky_r != ST_OK) begin
            status_nxt = sticky_r;
          end else begin
            case (in_ch.command)
              CMD_PUSH: begin
                if (count_r >= CW'(STACK_DEPTH)) begin
                  status_nxt = ST_OVERFLOW;
                end else begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + CW'(1);
                  res_nxt   = in_ch.operand_value;
                end
              end
              CMD_APPLY: begin
                if (count_r < CW'(2)) begin
                  status_nxt = ST_UNDERFLOW;
                end else begin
                  state_nxt = S_RD_A;
                end
              end
              CMD_FINISH: begin
                if (count_r == '0) begin
                  status_nxt = ST_UNDERFLOW;
                end else begin
                  count_nxt = count_r - CW'(1);
                  state_nxt = S_POP;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_RD_A: begin
        a_nxt     = ram_rdata;
        ram_raddr = AW'(count_r - CW'(2));
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        if (op_r == OP_DIV && ram_rdata == '0) begin
          status_nxt = ST_DIVZERO;
          state_nxt  = S_DONE;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          res_nxt   = alu_rsp.result;
          ram_we    = 1'b1;
          ram_waddr = AW'(count_r - CW'(2));
          ram_wdata = alu_rsp.result;
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        res_nxt   = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_res_nxt    = res_r;
          out_status_nxt = status_r;
          if (status_r != ST_OK) begin
            sticky_nxt = status_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sticky_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    op_r         <= op_nxt;
    a_r          <= a_nxt;
    res_r        <= res_nxt;
    out_res_r    <= out_res_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.status       = out_status_r;

endmodule

// File: bench/expr_result_checker.sv
`timescale 1ns / 1ps
module expr_result_checker import see_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  see_in_if                        in_mon,
  see_out_if                       out_mon,
  output int                       fail_count,
  output int                       pending,
  output int                       checked,
  output int                       depth_now,
  output int                       peak_depth,
  output logic signed [DATA_W-1:0] divisor_next
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } token_result_t;

  logic signed [DATA_W-1:0] value_store [STACK_DEPTH];
  int                       fill;
  status_t                  fault_latch;
  token_result_t            predicted_results [$];
  token_result_t            want;

  function automatic logic signed [DATA_W-1:0] quotient_toward_zero(
    input logic signed [DATA_W-1:0] num,
    input logic signed [DATA_W-1:0] den
  );
    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W-1:0] quo;
    num_mag = num[DATA_W-1] ? DATA_W'(0 - num) : num;
    den_mag = den[DATA_W-1] ? DATA_W'(0 - den) : den;
    quo     = num_mag / den_mag;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? DATA_W'(0 - quo) : quo;
  endfunction

  function automatic token_result_t evaluate_token(
    input logic [CMD_W-1:0]         cmd,
    input logic signed [DATA_W-1:0] val,
    input logic [OPC_W-1:0]         opc
  );
    token_result_t            res;
    logic signed [DATA_W-1:0] lhs;
    logic signed [DATA_W-1:0] rhs;
    res.value  = '0;
    res.status = ST_OK;
    if (fault_latch != ST_OK) begin
      res.status = fault_latch;
    end else begin
      case (cmd)
        CMD_PUSH: begin
          if (fill >= STACK_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            value_store[fill] = val;
            fill++;
            res.value = val;
          end
        end
        CMD_APPLY: begin
          if (fill < 2) begin
            res.status = ST_UNDERFLOW;
          end else begin
            lhs = value_store[fill-1];
            rhs = value_store[fill-2];
            case (opc)
              OP_ADD: res.value = lhs + rhs;
              OP_SUB: res.value = lhs - rhs;
              OP_MUL: res.value = lhs * rhs;
              default: begin
                if (rhs == 0) res.status = ST_DIVZERO;
                else res.value = quotient_toward_zero(lhs, rhs);
              end
            endcase
            if (res.status == ST_OK) begin
              fill--;
              value_store[fill-1] = res.value;
            end
          end
        end
        CMD_FINISH: begin
          if (fill == 0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            fill--;
            res.value = value_store[fill];
          end
        end
        default: ;
      endcase
    end
    if (res.status != ST_OK) begin
      fault_latch = res.status;
      res.value   = '0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill        = 0;
      fault_latch = ST_OK;
      predicted_results.delete();
      fail_count  = 0;
      checked     = 0;
      peak_depth  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        predicted_results.push_back(evaluate_token(in_mon.command, in_mon.operand_value,
                                                   in_mon.operator_code));
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat: value %0d status %0d", $time,
                   out_mon.result_value, out_mon.status);
        end else begin
          want = predicted_results.pop_front();
          checked++;
          if (out_mon.result_value !== want.value) begin
            fail_count++;
            $display("%0t: result_value expected %0d actual %0d", $time, want.value,
                     out_mon.result_value);
          end
          if (out_mon.status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_mon.status);
          end
        end
      end
    end
    pending      = predicted_results.size();
    depth_now    = fill;
    peak_depth   = (fill > peak_depth) ? fill : peak_depth;
    divisor_next = (fill >= 2) ? value_store[fill-2] : '0;
  end

endmodule

// File: bench/tb_stack_expression_evaluator_unit.sv
`timescale 1ns / 1ps
module tb_stack_expression_evaluator_unit;
  import see_pkg::*;

  localparam int                       ITEMS      = 1200;
  localparam int                       TAIL_ITEMS = 20;
  localparam logic [CMD_W-1:0]         CMD_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] MOST_NEG   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS   = 32'sh7fff_ffff;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  see_in_if  in_ch ();
  see_out_if out_ch ();

  int                       fail_count;
  int                       pending;
  int                       checked;
  int                       depth_now;
  int                       peak_depth;
  logic signed [DATA_W-1:0] divisor_next;

  int       burst_left;
  int       beats_sent;
  int       body_count;
  status_t  closing_fault;
  rx_mode_t rx_mode;
  int       rx_left;

  stack_expression_evaluator_unit #(.STACK_DEPTH(STACK_DEPTH_DEF)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  expr_result_checker #(.STACK_DEPTH(STACK_DEPTH_DEF)) i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .depth_now   (depth_now),
    .peak_depth  (peak_depth),
    .divisor_next(divisor_next)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    rx_left      = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(40, 400);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default:   out_ch.ready <= (rx_left % 7) < 3;
      endcase
    end
  end

  // called at a falling edge; returns at a falling edge after the beat
  task automatic drive_beat(input logic [CMD_W-1:0] cmd,
                            input logic signed [DATA_W-1:0] val,
                            input logic [OPC_W-1:0] opc);
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.operand_value <= val;
    in_ch.operator_code <= opc;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    burst_left--;
    @(negedge clk);
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic push_value(input logic signed [DATA_W-1:0] val);
    drive_beat(CMD_PUSH, val, OP_ADD);
  endtask

  task automatic apply_op(input op_t op);
    drive_beat(CMD_APPLY, $urandom, op);
  endtask

  task automatic finish_expr();
    drive_beat(CMD_FINISH, $urandom, OPC_W'($urandom_range(0, 3)));
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return int'($urandom_range(0, 40)) - 20;
      4: begin
        case ($urandom_range(0, 4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic random_apply();
    op_t op;
    op = op_t'($urandom_range(0, 3));
    if (op == OP_DIV && divisor_next == 0) op = OP_SUB;
    apply_op(op);
  endtask

  task automatic random_token();
    int roll;
    roll = $urandom_range(0, 99);
    if (depth_now < 2) begin
      if (depth_now == 1 && roll < 15) finish_expr();
      else push_value(pick_operand());
    end else if (depth_now >= 12) begin
      if (roll < 70) random_apply();
      else finish_expr();
    end else begin
      if (roll < 45) push_value(pick_operand());
      else if (roll < 85) random_apply();
      else finish_expr();
    end
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_PUSH;
    in_ch.operand_value = '0;
    in_ch.operator_code = OP_ADD;
    beats_sent          = 0;
    burst_left          = $urandom_range(1, 40);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    push_value(3);
    push_value(17);
    apply_op(OP_SUB);
    push_value(-1);
    push_value(MOST_NEG);
    apply_op(OP_DIV);
    push_value(MOST_POS);
    push_value(MOST_POS);
    apply_op(OP_ADD);
    push_value(MOST_POS);
    push_value(MOST_POS);
    apply_op(OP_MUL);
    push_value(2);
    push_value(-7);
    apply_op(OP_DIV);
    push_value(-2);
    push_value(7);
    apply_op(OP_DIV);
    push_value(5);
    push_value(0);
    apply_op(OP_DIV);
    drive_beat(CMD_UNUSED, MOST_NEG, OP_DIV);
    finish_expr();
    finish_expr();
    hold_until_drained();

    body_count = 0;
    while (body_count < ITEMS) begin
      if ($urandom_range(0, 149) == 0) hold_until_drained();
      if ($urandom_range(0, 24) == 0) begin
        drive_beat(CMD_UNUSED, $urandom, OPC_W'($urandom_range(0, 3)));
      end else if (body_count == ITEMS / 2) begin
        while (depth_now < STACK_DEPTH_DEF) begin
          push_value(pick_operand());
          body_count++;
        end
        while (depth_now > 3) begin
          if ($urandom_range(0, 3) == 0) finish_expr();
          else random_apply();
          body_count++;
        end
      end else begin
        random_token();
        body_count++;
      end
    end

    // drive one sticky fault as the run closes, then confirm it holds
    closing_fault = status_t'($urandom_range(1, 3));
    case (closing_fault)
      ST_OVERFLOW: begin
        while (depth_now < STACK_DEPTH_DEF) push_value(pick_operand());
        push_value(pick_operand());
      end
      ST_UNDERFLOW: begin
        if ($urandom_range(0, 1) == 0) begin
          while (depth_now > 1) finish_expr();
          random_apply();
        end else begin
          while (depth_now > 0) finish_expr();
          finish_expr();
        end
      end
      default: begin
        push_value(0);
        push_value(pick_operand());
        apply_op(OP_DIV);
      end
    endcase
    repeat (TAIL_ITEMS) drive_beat(CMD_W'($urandom_range(0, 3)), $urandom,
                                   OPC_W'($urandom_range(0, 3)));

    hold_until_drained();
    repeat (60) @(posedge clk);
    $display("Covered %0d input beats and %0d compared results; stack reached %0d of %0d.",
             beats_sent, checked, peak_depth, STACK_DEPTH_DEF);
    $display("Closed on a %s fault, held across %0d further beats.", closing_fault.name(),
             TAIL_ITEMS);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/see_pkg.sv
rtl/see_if.sv
rtl/see_ram.sv
rtl/see_alu.sv
rtl/stack_expression_evaluator_unit.sv
bench/expr_result_checker.sv
bench/tb_stack_expression_evaluator_unit.sv
